/* sv/ffra_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and codes for the first-fit region allocator.
// No dependencies; used by ffra_round, ffra_cell and the top level.
package ffra_pkg;

  localparam int DEF_MAX_REGIONS = 64;
  localparam int DEF_LINE_BYTES  = 64;

  localparam int ADDR_W = 32;   // region base / window base
  localparam int LEN_W  = 25;   // region length / window size
  localparam int SIZE_W = 26;   // rounded size, one spare bit to flag overflow
  localparam int END_W  = 33;   // base + length
  localparam int SUM_W  = 34;   // base + length + size
  localparam int CFG_AW = 3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic REG_WINDOW_BASE  = 1'b0;
  localparam logic REG_WINDOW_BYTES = 1'b1;

  localparam logic [ADDR_W-1:0] RST_WINDOW_BASE  = 32'h0400_0000;
  localparam logic [LEN_W-1:0]  RST_WINDOW_BYTES = 25'h020_0000;

  localparam logic [1:0] STAT_DONE       = 2'd0;
  localparam logic [1:0] STAT_NO_SPACE   = 2'd1;
  localparam logic [1:0] STAT_TABLE_FULL = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_EVAL,
    ST_SELECT,
    ST_COMMIT
  } ctl_state_t;

  typedef struct packed {
    logic              occ;
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } region_t;

  typedef struct packed {
    logic eval;
    logic load;
    logic take_prev;
    logic take_next;
  } cell_cmd_t;

endpackage

/* sv/first_fit_region_allocator.sv */
`timescale 1ns / 1ps
// First-fit region allocator: sorted region list held in a chain of cells.
// A request passes through ROUND (allocate only), EVAL, SELECT and COMMIT, and the result is
// registered on leaving COMMIT; ROUND does a reciprocal multiply and a multiply back unless the
// line size is a power of two. One request at a time: in_ready returns the cycle after the result
// is registered; a result still waiting on out_ready holds the commit. The cells test all gaps
// at once. Sync active-low reset empties the table and loads the window register defaults.
module first_fit_region_allocator #(
  parameter int MAX_REGIONS = ffra_pkg::DEF_MAX_REGIONS,
  parameter int LINE_BYTES  = ffra_pkg::DEF_LINE_BYTES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  logic [ffra_pkg::LEN_W-1:0]  in_request_bytes,
  input  logic [ffra_pkg::ADDR_W-1:0] in_free_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [ffra_pkg::ADDR_W-1:0] out_granted_address,
  output logic [ffra_pkg::LEN_W-1:0]  out_granted_bytes,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ffra_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam logic [ffra_pkg::SUM_W-1:0] ADDR_SPAN = ffra_pkg::SUM_W'(1) << ffra_pkg::ADDR_W;

  // configuration
  logic [ffra_pkg::ADDR_W-1:0] window_base_r, window_base_nxt;
  logic [ffra_pkg::LEN_W-1:0]  window_bytes_r, window_bytes_nxt;
  logic                        cfg_wr;
  logic                        cfg_idx;

  // control
  ffra_pkg::ctl_state_t        state_r, state_nxt;
  logic                        op_r, op_nxt;
  logic [ffra_pkg::ADDR_W-1:0] free_addr_r, free_addr_nxt;
  logic                        round_start;
  logic                        round_done;
  logic [ffra_pkg::SIZE_W-1:0] size_q;
  logic                        cell_eval;
  logic                        commit;

  // selection
  logic [MAX_REGIONS-1:0]      sel_r, sel_nxt;
  logic [MAX_REGIONS-1:0]      shift_r, shift_nxt;
  logic [ffra_pkg::END_W-1:0]  adr_r, adr_nxt;
  logic                        found_r, found_nxt;
  logic                        hit_r, hit_nxt;
  logic [MAX_REGIONS-1:0]      cand, cand_low, above, match_low, from_hit;
  logic [ffra_pkg::END_W-1:0]  adr_pick;

  // commit
  logic [ffra_pkg::SUM_W-1:0]  place_end, win_end;
  logic                        end_bad;
  logic [1:0]                  status;
  logic                        alloc_ok, free_ok;
  logic [MAX_REGIONS-1:0]      load_v, take_prev_v, take_next_v;

  // result register
  logic                        out_valid_r, out_valid_nxt;
  logic [1:0]                  out_status_r, out_status_nxt;
  logic [ffra_pkg::ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [ffra_pkg::LEN_W-1:0]  out_bytes_r, out_bytes_nxt;

  // cell chain
  ffra_pkg::region_t           cell_reg [MAX_REGIONS];
  logic [ffra_pkg::END_W-1:0]  cell_end [MAX_REGIONS];
  logic [ffra_pkg::END_W-1:0]  gap_addr [MAX_REGIONS];
  logic [MAX_REGIONS-1:0]      fit_v, match_v, occ_v;

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[2];

  always_comb begin
    window_base_nxt  = window_base_r;
    window_bytes_nxt = window_bytes_r;
    prdata           = '0;
    unique case (cfg_idx)
      ffra_pkg::REG_WINDOW_BASE: begin
        prdata = window_base_r;
        if (cfg_wr) window_base_nxt = pwdata;
      end
      ffra_pkg::REG_WINDOW_BYTES: begin
        prdata = {7'b0, window_bytes_r};
        if (cfg_wr) window_bytes_nxt = pwdata[ffra_pkg::LEN_W-1:0];
      end
      default: prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- rounding
  ffra_round #(
    .LINE_BYTES (LINE_BYTES)
  ) u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (round_start),
    .req_bytes (in_request_bytes),
    .done      (round_done),
    .size      (size_q)
  );

  // ---------------------------------------------------------------- cells
  genvar gi;
  generate
    for (gi = 0; gi < MAX_REGIONS; gi++) begin : g_cell
      logic [ffra_pkg::END_W-1:0] gap_base;
      ffra_pkg::region_t          prev_reg;
      ffra_pkg::region_t          next_reg;
      ffra_pkg::cell_cmd_t        cmd;

      if (gi == 0) begin : g_head
        assign gap_base = {1'b0, window_base_r};
        assign prev_reg = '0;
      end else begin : g_mid
        assign gap_base = cell_end[gi-1];
        assign prev_reg = cell_reg[gi-1];
      end

      if (gi == MAX_REGIONS - 1) begin : g_tail
        assign next_reg = '0;
      end else begin : g_body
        assign next_reg = cell_reg[gi+1];
      end

      assign cmd = '{eval: cell_eval, load: load_v[gi], take_prev: take_prev_v[gi],
                     take_next: take_next_v[gi]};
      assign gap_addr[gi] = gap_base;
      assign occ_v[gi]    = cell_reg[gi].occ;

      ffra_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .size      (size_q),
        .free_addr (free_addr_r),
        .gap_base  (gap_base),
        .prev_reg  (prev_reg),
        .next_reg  (next_reg),
        .new_start (adr_r[ffra_pkg::ADDR_W-1:0]),
        .new_len   (size_q[ffra_pkg::LEN_W-1:0]),
        .cur_reg   (cell_reg[gi]),
        .cur_end   (cell_end[gi]),
        .fit       (fit_v[gi]),
        .match     (match_v[gi])
      );
    end
  endgenerate

  // ---------------------------------------------------------------- selection
  // Insertion slot: first fitting gap, else first empty slot. None means past the last cell.
  always_comb begin
    cand      = fit_v | ~occ_v;
    cand_low  = cand & (~cand + MAX_REGIONS'(1));
    above     = ~((cand_low << 1) - MAX_REGIONS'(1));
    match_low = match_v & (~match_v + MAX_REGIONS'(1));
    from_hit  = ~(match_low - MAX_REGIONS'(1));

    adr_pick = '0;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      adr_pick = adr_pick | ({ffra_pkg::END_W{cand_low[i]}} & gap_addr[i]);
    end
    if (cand_low == '0) adr_pick = cell_end[MAX_REGIONS-1];

    sel_nxt   = sel_r;
    shift_nxt = shift_r;
    adr_nxt   = adr_r;
    found_nxt = found_r;
    hit_nxt   = hit_r;
    if (state_r == ffra_pkg::ST_SELECT) begin
      sel_nxt   = cand_low;
      shift_nxt = (op_r == ffra_pkg::OP_ALLOC) ? above : from_hit;
      adr_nxt   = adr_pick;
      found_nxt = |fit_v;
      hit_nxt   = |match_v;
    end
  end

  // ---------------------------------------------------------------- decision
  always_comb begin
    place_end = ffra_pkg::SUM_W'(adr_r) + ffra_pkg::SUM_W'(size_q);
    win_end   = ffra_pkg::SUM_W'(window_base_r) + ffra_pkg::SUM_W'(window_bytes_r);
    // window end is only checked when placing after the last region
    end_bad   = (place_end > win_end) || (place_end > ADDR_SPAN);

    if (op_r == ffra_pkg::OP_ALLOC) begin
      if (size_q[ffra_pkg::SIZE_W-1]) begin
        status = ffra_pkg::STAT_NO_SPACE;
      end else if (!found_r && end_bad) begin
        status = ffra_pkg::STAT_NO_SPACE;
      end else if (occ_v[MAX_REGIONS-1]) begin
        status = ffra_pkg::STAT_TABLE_FULL;
      end else begin
        status = ffra_pkg::STAT_DONE;
      end
    end else begin
      status = hit_r ? ffra_pkg::STAT_DONE : ffra_pkg::STAT_NOT_FOUND;
    end

    alloc_ok    = commit && (op_r == ffra_pkg::OP_ALLOC) && (status == ffra_pkg::STAT_DONE);
    free_ok     = commit && (op_r == ffra_pkg::OP_FREE) && (status == ffra_pkg::STAT_DONE);
    load_v      = alloc_ok ? sel_r : '0;
    take_prev_v = alloc_ok ? shift_r : '0;
    take_next_v = free_ok ? shift_r : '0;
  end

  // ---------------------------------------------------------------- control FSM
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    free_addr_nxt = free_addr_r;
    in_ready      = 1'b0;
    round_start   = 1'b0;
    cell_eval     = 1'b0;
    commit        = 1'b0;
    unique case (state_r)
      ffra_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt        = in_operation;
          free_addr_nxt = in_free_address;
          if (in_operation == ffra_pkg::OP_ALLOC) begin
            round_start = 1'b1;
            state_nxt   = ffra_pkg::ST_ROUND;
          end else begin
            state_nxt = ffra_pkg::ST_EVAL;
          end
        end
      end
      ffra_pkg::ST_ROUND: begin
        if (round_done) state_nxt = ffra_pkg::ST_EVAL;
      end
      ffra_pkg::ST_EVAL: begin
        cell_eval = 1'b1;
        state_nxt = ffra_pkg::ST_SELECT;
      end
      ffra_pkg::ST_SELECT: begin
        state_nxt = ffra_pkg::ST_COMMIT;
      end
      ffra_pkg::ST_COMMIT: begin
        if (!out_valid_r || out_ready) begin
          commit    = 1'b1;
          state_nxt = ffra_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ffra_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- result register
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_bytes_nxt  = out_bytes_r;
    if (commit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status;
      out_addr_nxt   = alloc_ok ? adr_r[ffra_pkg::ADDR_W-1:0] : '0;
      out_bytes_nxt  = alloc_ok ? size_q[ffra_pkg::LEN_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ffra_pkg::ST_IDLE;
      out_valid_r    <= 1'b0;
      window_base_r  <= ffra_pkg::RST_WINDOW_BASE;
      window_bytes_r <= ffra_pkg::RST_WINDOW_BYTES;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      window_base_r  <= window_base_nxt;
      window_bytes_r <= window_bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    free_addr_r  <= free_addr_nxt;
    sel_r        <= sel_nxt;
    shift_r      <= shift_nxt;
    adr_r        <= adr_nxt;
    found_r      <= found_nxt;
    hit_r        <= hit_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_bytes_r  <= out_bytes_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_addr_r;
  assign out_granted_bytes   = out_bytes_r;

endmodule

/* sv/ffra_round.sv */
`timescale 1ns / 1ps
// Rounds a request size up to a whole number of lines.
// Power-of-two line: the padded size is masked. Otherwise a registered reciprocal multiply, then multiply back.
// Uses ffra_pkg.
module ffra_round #(
  parameter int LINE_BYTES = ffra_pkg::DEF_LINE_BYTES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ffra_pkg::LEN_W-1:0]  req_bytes,
  output logic                        done,
  output logic [ffra_pkg::SIZE_W-1:0] size
);

  localparam bit IS_POW2 = (LINE_BYTES & (LINE_BYTES - 1)) == 0;

  logic                        done_r, done_nxt;
  logic [ffra_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic [ffra_pkg::SIZE_W-1:0] padded;

  assign padded = {1'b0, req_bytes} + ffra_pkg::SIZE_W'(LINE_BYTES - 1);

  generate
    if (IS_POW2) begin : g_pow2
      always_comb begin
        done_nxt = start;
        size_nxt = start ? (padded & ~ffra_pkg::SIZE_W'(LINE_BYTES - 1)) : size_r;
      end
    end else begin : g_div
      // floor(x / LINE_BYTES) = (x * RECIP) >> SHIFT, exact for every SIZE_W-bit x
      localparam int SHIFT = ffra_pkg::SIZE_W + $clog2(LINE_BYTES);
      localparam longint unsigned RECIP_L =
          ((64'd1 << SHIFT) + 64'(LINE_BYTES) - 64'd1) / 64'(LINE_BYTES);
      localparam int RCP_W = ffra_pkg::SIZE_W + 1;
      localparam int PW    = ffra_pkg::SIZE_W + RCP_W;
      localparam int BW    = ffra_pkg::SIZE_W + $clog2(LINE_BYTES);
      localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_L);

      logic                        busy_r, busy_nxt;
      logic [ffra_pkg::SIZE_W-1:0] quo_r, quo_nxt;
      logic [PW-1:0]               prod;
      logic [BW-1:0]               back;

      always_comb begin
        prod     = PW'(padded) * PW'(RECIP);
        back     = BW'(quo_r) * BW'(LINE_BYTES);
        busy_nxt = start;
        quo_nxt  = start ? ffra_pkg::SIZE_W'(prod >> SHIFT) : quo_r;
        done_nxt = busy_r;
        size_nxt = busy_r ? back[ffra_pkg::SIZE_W-1:0] : size_r;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
        end else begin
          busy_r <= busy_nxt;
        end
      end

      always_ff @(posedge clk) begin
        quo_r <= quo_nxt;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r <= size_nxt;
  end

  assign done = done_r;
  assign size = size_r;

endmodule

/* sv/ffra_cell.sv */
`timescale 1ns / 1ps
// One slot of the sorted region list: holds a region, tests the gap in front of it,
// and shifts up or down with its neighbors on insert and remove. Uses ffra_pkg.
module ffra_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ffra_pkg::cell_cmd_t         cmd,
  input  logic [ffra_pkg::SIZE_W-1:0] size,
  input  logic [ffra_pkg::ADDR_W-1:0] free_addr,
  input  logic [ffra_pkg::END_W-1:0]  gap_base,
  input  ffra_pkg::region_t           prev_reg,
  input  ffra_pkg::region_t           next_reg,
  input  logic [ffra_pkg::ADDR_W-1:0] new_start,
  input  logic [ffra_pkg::LEN_W-1:0]  new_len,
  output ffra_pkg::region_t           cur_reg,
  output logic [ffra_pkg::END_W-1:0]  cur_end,
  output logic                        fit,
  output logic                        match
);

  logic                        occ_r, occ_nxt;
  logic [ffra_pkg::ADDR_W-1:0] start_r, start_nxt;
  logic [ffra_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic                        fit_r, fit_nxt;
  logic                        match_r, match_nxt;
  logic [ffra_pkg::SUM_W-1:0]  gap_need;

  always_comb begin
    occ_nxt   = occ_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    if (cmd.load) begin
      occ_nxt   = 1'b1;
      start_nxt = new_start;
      len_nxt   = new_len;
    end else if (cmd.take_prev) begin
      occ_nxt   = prev_reg.occ;
      start_nxt = prev_reg.start;
      len_nxt   = prev_reg.len;
    end else if (cmd.take_next) begin
      occ_nxt   = next_reg.occ;
      start_nxt = next_reg.start;
      len_nxt   = next_reg.len;
    end

    // gap between the previous region's end (the window base for the first slot) and this base
    gap_need  = ffra_pkg::SUM_W'(gap_base) + ffra_pkg::SUM_W'(size);
    fit_nxt   = cmd.eval ? (occ_r && (gap_need <= ffra_pkg::SUM_W'(start_r))) : fit_r;
    match_nxt = cmd.eval ? (occ_r && (start_r == free_addr)) : match_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    len_r   <= len_nxt;
    fit_r   <= fit_nxt;
    match_r <= match_nxt;
  end

  assign cur_reg = '{occ: occ_r, start: start_r, len: len_r};
  assign cur_end = ffra_pkg::END_W'(start_r) + ffra_pkg::END_W'(len_r);
  assign fit     = fit_r;
  assign match   = match_r;

endmodule
